>>> hw/rtl/svt_pkg.sv
// Shared constants and types for the sorted value table.
`timescale 1ns / 1ps

package svt_pkg;

    localparam int CAPACITY  = 16;
    localparam int DATA_W    = 32;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int OUT_CNT_W = 5;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    typedef struct packed {
        logic                     ins_en;
        logic                     del_en;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctrl;

    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] value;
    } t_cell_link;

    typedef struct packed {
        logic match;
        logic ge;
    } t_cell_stat;

endpackage

>>> hw/rtl/sorted_value_table.sv
// Top level of the sorted value table: a chain of cells plus request control.
// Usage:
//   Raise start with i_req_type (0 insert, 1 delete) and i_value; the word is
//   taken at the clock edge where start is high and busy is low.
//   Insert places the value after all held equal values; delete removes the
//   oldest held copy of the value and closes the gap.
//   One result word follows per request, on the cycle after acceptance, marked
//   by o_valid for a single cycle: o_status, o_entry_count, o_smallest_value.
//   A new request may be given every cycle while busy is low: every cell
//   compares its value to the request and shifts to or from its neighbor in
//   the same edge, so the table updates at the edge that accepts the request.
//   busy is high only while reset is applied and in the cycle after it.
//   Reset empties the table; no clearing pass is needed, each cell carries a
//   valid bit. The receiver cannot stall: results must be taken when shown.
`timescale 1ns / 1ps

module sorted_value_table (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_req_type,
    input  logic signed [svt_pkg::DATA_W-1:0]    i_value,
    output logic                                 o_valid,
    output logic [1:0]                           o_status,
    output logic [svt_pkg::OUT_CNT_W-1:0]        o_entry_count,
    output logic signed [svt_pkg::DATA_W-1:0]    o_smallest_value
);

    localparam int CAP = svt_pkg::CAPACITY;

    svt_pkg::t_cell_ctrl               ctrl;
    svt_pkg::t_cell_link               link   [CAP];
    svt_pkg::t_cell_stat               stat   [CAP];
    logic                              gt     [CAP];
    logic [CAP-1:0]                    match_vec;
    logic [CAP-1:0]                    valid_vec;

    logic                              r_busy;
    logic [svt_pkg::CNT_W-1:0]         r_count;
    logic [svt_pkg::CNT_W-1:0]         n_count;
    logic                              r_valid;
    logic [1:0]                        r_status;
    logic [1:0]                        n_status;
    logic [svt_pkg::OUT_CNT_W-1:0]     r_entry_count;
    logic signed [svt_pkg::DATA_W-1:0] r_smallest;
    logic signed [svt_pkg::DATA_W-1:0] n_smallest;

    logic accept;
    logic found;
    logic full;
    logic ins_ok;
    logic del_ok;

    assign busy   = r_busy;
    assign accept = start && !r_busy;
    assign found  = |match_vec;
    assign full   = (r_count == svt_pkg::CNT_W'(CAP));
    assign ins_ok = accept && (i_req_type == svt_pkg::REQ_INSERT) && !full;
    assign del_ok = accept && (i_req_type == svt_pkg::REQ_DELETE) && found;

    assign ctrl.ins_en = ins_ok;
    assign ctrl.del_en = del_ok;
    assign ctrl.value  = i_value;

    genvar g;
    generate
        for (g = 0; g < CAP; g++) begin : g_cell
            svt_pkg::t_cell_link prev_l;
            svt_pkg::t_cell_link next_l;
            logic                prev_gt;

            if (g == 0) begin : g_head
                assign prev_l  = '0;
                assign prev_gt = 1'b0;
            end else begin : g_mid
                assign prev_l  = link[g-1];
                assign prev_gt = gt[g-1];
            end
            if (g == CAP - 1) begin : g_tail
                assign next_l = '0;
            end else begin : g_body
                assign next_l = link[g+1];
            end

            svt_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctrl    (ctrl),
                .i_prev    (prev_l),
                .i_prev_gt (prev_gt),
                .i_next    (next_l),
                .o_link    (link[g]),
                .o_gt      (gt[g]),
                .o_stat    (stat[g])
            );

            assign match_vec[g] = stat[g].match;
            assign valid_vec[g] = link[g].valid;
        end
    endgenerate

    always_comb begin
        n_count    = r_count;
        n_status   = svt_pkg::ST_DONE;
        n_smallest = link[0].valid ? link[0].value : '0;
        if (i_req_type == svt_pkg::REQ_INSERT) begin
            if (full) begin
                n_status = svt_pkg::ST_FULL;
            end else begin
                n_count = r_count + 1'b1;
                if (!link[0].valid || (i_value < link[0].value)) begin
                    n_smallest = i_value;
                end
            end
        end else begin
            if (!found) begin
                n_status = svt_pkg::ST_NOT_FOUND;
            end else begin
                n_count = r_count - 1'b1;
                if (stat[0].ge) begin
                    n_smallest = link[1].valid ? link[1].value : '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_busy  <= 1'b0;
            r_valid <= accept;
            if (ins_ok || del_ok) begin
                r_count <= n_count;
            end
        end
        if (accept) begin
            r_status      <= n_status;
            r_entry_count <= svt_pkg::OUT_CNT_W'(n_count);
            r_smallest    <= n_smallest;
        end
    end

    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_entry_count    = r_entry_count;
    assign o_smallest_value = r_smallest;

    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(valid_vec) == r_count)
        else $error("held count differs from occupied cells");

    a_cells_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (valid_vec & (valid_vec + 1'b1)) == '0)
        else $error("occupied cells are not packed at the head");

    a_result_follows_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept))
        else $error("result without a request");

    a_full_status_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == svt_pkg::ST_FULL))
            |-> (r_count == svt_pkg::CNT_W'(CAP)))
        else $error("full refusal while table not full");

endmodule

>>> hw/rtl/svt_cell.sv
// One slot of the sorted table: holds a value and shifts with its neighbors.
`timescale 1ns / 1ps

module svt_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  svt_pkg::t_cell_ctrl i_ctrl,
    input  svt_pkg::t_cell_link i_prev,
    input  logic                i_prev_gt,
    input  svt_pkg::t_cell_link i_next,
    output svt_pkg::t_cell_link o_link,
    output logic                o_gt,
    output svt_pkg::t_cell_stat o_stat
);

    logic                             r_valid;
    logic signed [svt_pkg::DATA_W-1:0] r_value;
    logic                             n_valid;
    logic signed [svt_pkg::DATA_W-1:0] n_value;
    logic                             own_gt;

    // free slot or strictly greater value: insert point at or before this cell
    assign own_gt = !r_valid || (r_value > i_ctrl.value);

    assign o_gt        = own_gt;
    assign o_stat.match = r_valid && (r_value == i_ctrl.value);
    assign o_stat.ge    = r_valid && (r_value >= i_ctrl.value);
    assign o_link.valid = r_valid;
    assign o_link.value = r_value;

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_ctrl.ins_en) begin
            if (i_prev_gt) begin
                n_valid = i_prev.valid;
                n_value = i_prev.value;
            end else if (own_gt) begin
                n_valid = 1'b1;
                n_value = i_ctrl.value;
            end
        end else if (i_ctrl.del_en && o_stat.ge) begin
            n_valid = i_next.valid;
            n_value = i_next.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_value <= n_value;
    end

endmodule

>>> bench/sorted_value_table_test.sv
// Self-checking testbench for the sorted value table: scoreboard class and driver.
`timescale 1ns / 1ps

class sorted_table_scoreboard;
    typedef struct packed {
        logic [1:0]                          status;
        logic [svt_pkg::OUT_CNT_W-1:0]       count;
        logic signed [svt_pkg::DATA_W-1:0]   smallest;
    } t_answer;

    logic signed [svt_pkg::DATA_W-1:0] held_values[$];
    t_answer pending_answers[$];
    int errors;
    int checked;
    int inserts;
    int deletes;
    int refused_full;
    int not_found;
    int emptied;

    function void note_request(logic req_type, logic signed [svt_pkg::DATA_W-1:0] value);
        t_answer ans;
        int pos;
        ans.status = svt_pkg::ST_DONE;
        pos = 0;
        if (req_type == svt_pkg::REQ_INSERT) begin
            inserts++;
            if (held_values.size() >= svt_pkg::CAPACITY) begin
                ans.status = svt_pkg::ST_FULL;
                refused_full++;
            end else begin
                // equal values stay in arrival order
                while (pos < held_values.size() && held_values[pos] <= value) pos++;
                held_values.insert(pos, value);
            end
        end else begin
            deletes++;
            while (pos < held_values.size() && held_values[pos] != value) pos++;
            if (pos == held_values.size()) begin
                ans.status = svt_pkg::ST_NOT_FOUND;
                not_found++;
            end else begin
                held_values.delete(pos);
                if (held_values.size() == 0) emptied++;
            end
        end
        ans.count    = svt_pkg::OUT_CNT_W'(held_values.size());
        ans.smallest = (held_values.size() > 0) ? held_values[0] : '0;
        pending_answers.push_back(ans);
    endfunction

    function void check_answer(logic [1:0] status, logic [svt_pkg::OUT_CNT_W-1:0] count,
                               logic signed [svt_pkg::DATA_W-1:0] smallest);
        t_answer want;
        checked++;
        if (pending_answers.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected word: status %0d count %0d smallest %0d",
                         status, count, smallest);
            return;
        end
        want = pending_answers.pop_front();
        if (status !== want.status || count !== want.count || smallest !== want.smallest) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: want status %0d count %0d smallest %0d, got %0d %0d %0d",
                         want.status, want.count, want.smallest, status, count, smallest);
        end
    endfunction

    function logic signed [svt_pkg::DATA_W-1:0] pick_held();
        if (held_values.size() == 0) return '0;
        return held_values[$urandom_range(0, held_values.size() - 1)];
    endfunction
endclass

module sorted_value_table_test;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                start = 1'b0;
    logic                                i_req_type = svt_pkg::REQ_INSERT;
    logic signed [svt_pkg::DATA_W-1:0]   i_value = '0;
    logic                                busy;
    logic                                o_valid;
    logic [1:0]                          o_status;
    logic [svt_pkg::OUT_CNT_W-1:0]       o_entry_count;
    logic signed [svt_pkg::DATA_W-1:0]   o_smallest_value;

    sorted_table_scoreboard table_check = new;

    sorted_value_table dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_req_type       (i_req_type),
        .i_value          (i_value),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_entry_count    (o_entry_count),
        .o_smallest_value (o_smallest_value)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("sorted_value_table verification failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) table_check.check_answer(o_status, o_entry_count, o_smallest_value);
            if (start && !busy) table_check.note_request(i_req_type, i_value);
        end
    end

    task automatic send_word(input logic req_type,
                             input logic signed [svt_pkg::DATA_W-1:0] value);
        start      <= 1'b1;
        i_req_type <= req_type;
        i_value    <= value;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic pause(input int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [svt_pkg::DATA_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: rand_value = int'($urandom_range(0, 15)) - 8;
            5: begin
                case ($urandom_range(0, 3))
                    0: rand_value = 32'h7FFF_FFFF;
                    1: rand_value = 32'h8000_0000;
                    2: rand_value = '0;
                    default: rand_value = '1;
                endcase
            end
            default: rand_value = $urandom;
        endcase
    endfunction

    initial begin
        logic signed [svt_pkg::DATA_W-1:0] fill_values [16];
        int sent;
        int burst;
        int insert_pct;
        int wait_cycles;
        logic req_type;
        logic signed [svt_pkg::DATA_W-1:0] value;

        fill_values = '{32'h7FFF_FFFF, 32'h8000_0000, 0, 0, -1, 5, 3, 3,
                        -7, 100, -100, 3, 32'h4000_0000, 32'hC000_0000, 1, -2};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty delete, fill with extremes and duplicates, refused insert, deletes
        send_word(svt_pkg::REQ_DELETE, '0);
        foreach (fill_values[k]) send_word(svt_pkg::REQ_INSERT, fill_values[k]);
        send_word(svt_pkg::REQ_INSERT, 42);
        send_word(svt_pkg::REQ_DELETE, 7);
        send_word(svt_pkg::REQ_DELETE, '0);
        send_word(svt_pkg::REQ_DELETE, 32'h8000_0000);
        send_word(svt_pkg::REQ_DELETE, 32'h7FFF_FFFF);
        send_word(svt_pkg::REQ_DELETE, 3);
        pause($urandom_range(1, 4));

        sent = 0;
        insert_pct = 50;
        while (sent < 900) begin
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 2))
                    0: insert_pct = 80;
                    1: insert_pct = 20;
                    default: insert_pct = 50;
                endcase
            end
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst; k++) begin
                req_type = ($urandom_range(0, 99) < insert_pct) ?
                           svt_pkg::REQ_INSERT : svt_pkg::REQ_DELETE;
                if (req_type == svt_pkg::REQ_DELETE && $urandom_range(0, 3) != 0)
                    value = table_check.pick_held();
                else
                    value = rand_value();
                send_word(req_type, value);
                sent++;
            end
            pause(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
        end
        start <= 1'b0;

        wait_cycles = 0;
        while (table_check.pending_answers.size() != 0 && wait_cycles < 100) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (4) @(posedge i_clk);

        $display("checked %0d words: %0d inserts (%0d refused full), %0d deletes (%0d absent)",
                 table_check.checked, table_check.inserts, table_check.refused_full,
                 table_check.deletes, table_check.not_found);
        $display("table drained to empty %0d times; %0d mismatches, %0d words never returned",
                 table_check.emptied, table_check.errors, table_check.pending_answers.size());
        if (table_check.errors == 0 && table_check.pending_answers.size() == 0)
            $display("sorted_value_table verification clean");
        else
            $display("sorted_value_table verification failed");
        $finish;
    end
endmodule
